FILE: rtl/ppfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfm_pkg - shared types and constants for the pulse period frequency meter
// Field widths, edge stage codes, event kinds, sequencer states and the
// control/status bundles between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
package ppfm_pkg;

    localparam int TICK_W  = 23;
    localparam int COUNT_W = 16;
    localparam int RATE_W  = 31;
    localparam int STAGE_W = 2;
    localparam int FRAC_W  = 8;

    // output item packing: rate_q8, edge_stage_out, zero fill to whole bytes
    localparam int OUT_BITS   = RATE_W + STAGE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [TICK_W-1:0] TICK_RATE_RESET = 23'd2000000;

    localparam logic [STAGE_W-1:0] STAGE_NONE   = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_FIRST  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_SECOND = 2'd2;

    localparam logic FUNC_CAPTURE  = 1'b0;
    localparam logic FUNC_OVERFLOW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/ppfm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfm_div - serial restoring divider
// One quotient bit per cycle: (tick_rate << 8) / period.
// ----------------------------------------------------------------------------
module ppfm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ppfm_pkg::t_div_ctrl              i_ctrl,
    input  logic [ppfm_pkg::RATE_W-1:0]      i_dividend,
    input  logic [ppfm_pkg::COUNT_W-1:0]     i_divisor,
    output ppfm_pkg::t_div_stat              o_stat,
    output logic [ppfm_pkg::RATE_W-1:0]      o_quotient
);

    localparam int STEPS  = ppfm_pkg::RATE_W;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic [CNT_W-1:0]              r_cnt,  n_cnt;
    logic [ppfm_pkg::COUNT_W-1:0]  r_rem,  n_rem;
    logic [ppfm_pkg::RATE_W-1:0]   r_quo,  n_quo;
    logic [ppfm_pkg::COUNT_W-1:0]  r_div;
    logic [ppfm_pkg::COUNT_W:0]    w_trial;
    logic [ppfm_pkg::COUNT_W:0]    w_diff;
    logic                          w_fits;

    // shift the next dividend bit into the partial remainder and try to subtract
    assign w_trial = {r_rem, r_quo[ppfm_pkg::RATE_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_comb begin
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        if (i_ctrl.start) begin
            n_cnt = CNT_W'(STEPS);
            n_rem = '0;
            n_quo = i_dividend;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_rem = w_fits ? w_diff[ppfm_pkg::COUNT_W-1:0] : w_trial[ppfm_pkg::COUNT_W-1:0];
            n_quo = {r_quo[ppfm_pkg::RATE_W-2:0], w_fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_ctrl.start) begin
            r_div <= i_divisor;
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = (r_cnt == CNT_W'(1));
    assign o_quotient  = n_quo;

endmodule

FILE: rtl/pulse_period_frequency_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_period_frequency_meter_unit - reciprocal pulse frequency meter
// Tracks the latest capture period and an edge stage, and on a timer overflow after a
// second-stage edge works out rate = tick_rate * 256 / period with a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis: tuser is the event kind (capture or timer
//   overflow), tdata the captured count. Each item gives exactly one result
//   item on m_axis: rate in hertz with 8 fraction bits, and the edge stage.
//   The tick rate is written through i_cfg_we / i_cfg_wdata while idle.
//   Sequence: a capture, or an overflow that needs no divide, goes from
//   acceptance through the output state to the output register, which raises
//   m_axis_tvalid; an overflow that recomputes the rate first passes the
//   divide state, where the divider produces one quotient bit per cycle. The
//   block takes one item at a time: the next item is accepted only once the
//   previous result has been loaded into the output register.
//   Reset clears the edge stage, window flag, period and rate, sets the tick
//   rate to 2000000 and empties the output register.
//   While the receiver stalls, the result waits in the output register; a
//   further item may be accepted, and its result waits inside the block
//   until the register is free.
// ----------------------------------------------------------------------------
module pulse_period_frequency_meter_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [ppfm_pkg::TICK_W-1:0]           i_cfg_wdata,   // tick_rate
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [ppfm_pkg::COUNT_W-1:0]          s_axis_tdata,  // [15:0] capture_count
    input  logic                                  s_axis_tuser,  // [0] func
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [ppfm_pkg::OUT_DATA_W-1:0]       m_axis_tdata   // [30:0] rate_q8,
                                                                 // [32:31] edge_stage_out,
                                                                 // [39:33] zero
);

    ppfm_pkg::t_state              r_state, n_state;
    logic [ppfm_pkg::TICK_W-1:0]   r_tick;
    logic [ppfm_pkg::STAGE_W-1:0]  r_stage;
    logic                          r_win;
    logic [ppfm_pkg::COUNT_W-1:0]  r_period;
    logic [ppfm_pkg::RATE_W-1:0]   r_rate;
    logic                          r_m_valid;
    logic [ppfm_pkg::RATE_W-1:0]   r_m_rate;
    logic [ppfm_pkg::STAGE_W-1:0]  r_m_stage;

    logic                          w_in_acc;
    logic                          w_is_ovf;
    logic                          w_need_div;
    logic                          w_out_load;
    ppfm_pkg::t_div_ctrl           w_div_ctrl;
    ppfm_pkg::t_div_stat           w_div_stat;
    logic [ppfm_pkg::RATE_W-1:0]   w_quotient;
    logic [ppfm_pkg::RATE_W-1:0]   w_dividend;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_is_ovf   = (s_axis_tuser == ppfm_pkg::FUNC_OVERFLOW);
    assign w_need_div = w_is_ovf && r_win && (r_stage == ppfm_pkg::STAGE_SECOND)
                        && (r_period != '0);
    assign w_dividend = {r_tick, {ppfm_pkg::FRAC_W{1'b0}}};

    ppfm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_dividend),
        .i_divisor  (r_period),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ppfm_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = w_need_div ? ppfm_pkg::ST_DIV : ppfm_pkg::ST_OUT;
                end
            end
            ppfm_pkg::ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ppfm_pkg::ST_OUT;
                end
            end
            ppfm_pkg::ST_OUT: begin
                if (w_out_load) begin
                    n_state = ppfm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ppfm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready    = 1'b0;
        w_div_ctrl.start = 1'b0;
        w_out_load       = 1'b0;
        case (r_state)
            ppfm_pkg::ST_IDLE: begin
                s_axis_tready    = 1'b1;
                w_div_ctrl.start = s_axis_tvalid && w_need_div;
            end
            ppfm_pkg::ST_OUT: begin
                w_out_load = !r_m_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppfm_pkg::ST_IDLE;
            r_tick    <= ppfm_pkg::TICK_RATE_RESET;
            r_stage   <= ppfm_pkg::STAGE_NONE;
            r_win     <= 1'b0;
            r_period  <= '0;
            r_rate    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
            if (w_in_acc) begin
                if (!w_is_ovf) begin
                    if (s_axis_tdata != '0) begin
                        r_period <= s_axis_tdata;
                        r_win    <= 1'b1;
                        r_stage  <= (r_stage == ppfm_pkg::STAGE_NONE) ?
                                    ppfm_pkg::STAGE_FIRST : ppfm_pkg::STAGE_SECOND;
                    end
                end else begin
                    if (!r_win) begin
                        r_rate  <= '0;
                        r_stage <= ppfm_pkg::STAGE_NONE;
                    end else if ((r_stage == ppfm_pkg::STAGE_SECOND) && (r_period == '0)) begin
                        r_rate <= '0;
                    end
                    r_win <= 1'b0;
                end
            end
            if (w_div_stat.done) begin
                r_rate <= w_quotient;
            end
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_m_rate  <= r_rate;
            r_m_stage <= r_stage;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(ppfm_pkg::OUT_DATA_W - ppfm_pkg::OUT_BITS){1'b0}},
                            r_m_stage, r_m_rate};

    // no new item while the divider is still iterating
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && w_div_stat.busy))
        else $error("item accepted while divider busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ppfm_pkg::ST_DIV))
        else $error("divider finished outside divide state");

    a_stage_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stage == ppfm_pkg::STAGE_NONE) || (r_stage == ppfm_pkg::STAGE_FIRST)
        || (r_stage == ppfm_pkg::STAGE_SECOND))
        else $error("edge stage out of range");

    // overflow with no edge in the window zeroes the rate and the stage
    a_timeout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_ovf && !r_win) |=>
        ((r_rate == '0) && (r_stage == ppfm_pkg::STAGE_NONE)))
        else $error("timeout did not clear rate");

endmodule

FILE: tb/sv/ppfm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppfm_checker - result checker for the pulse period frequency meter
// Watches the configuration port and both stream channels, keeps its own
// copy of the meter state, predicts one reading per accepted event and
// compares each returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ppfm_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppfm_pkg::TICK_W-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [ppfm_pkg::COUNT_W-1:0]    s_axis_tdata,  // [15:0] capture_count
    input  logic                            s_axis_tuser,  // [0] func
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [ppfm_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // [30:0] rate_q8,
                                                           // [32:31] edge_stage_out
    output int                              o_fail_count,
    output int                              o_pending
);
    import ppfm_pkg::*;

    typedef struct packed {
        logic [RATE_W-1:0]  rate_q8;
        logic [STAGE_W-1:0] stage;
    } t_reading;

    logic [TICK_W-1:0]  tick_rate;
    logic [STAGE_W-1:0] edge_stage;
    logic               edge_seen;
    logic [COUNT_W-1:0] period;
    logic [RATE_W-1:0]  rate;
    t_reading           expected_readings[$];

    // floor(ticks * 256 / period), zero for a zero period
    function automatic logic [RATE_W-1:0] reciprocal_rate(input logic [TICK_W-1:0]  ticks,
                                                          input logic [COUNT_W-1:0] per);
        logic [TICK_W+FRAC_W-1:0] scaled;
        if (per == '0)
            return '0;
        scaled = {ticks, {FRAC_W{1'b0}}} / per;
        return scaled[RATE_W-1:0];
    endfunction

    task automatic apply_event(input logic func, input logic [COUNT_W-1:0] count,
                               output t_reading reading);
        if (func == FUNC_CAPTURE) begin
            // a zero count leaves the state unchanged
            if (count != '0) begin
                period     = count;
                edge_seen  = 1'b1;
                edge_stage = (edge_stage == STAGE_NONE) ? STAGE_FIRST : STAGE_SECOND;
            end
        end else begin
            if (edge_seen) begin
                if (edge_stage == STAGE_SECOND)
                    rate = reciprocal_rate(tick_rate, period);
            end else begin
                rate       = '0;
                edge_stage = STAGE_NONE;
            end
            edge_seen = 1'b0;
        end
        reading.rate_q8 = rate;
        reading.stage   = edge_stage;
    endtask

    always @(posedge i_clk) begin : watch
        t_reading want;
        t_reading got;
        if (!i_rst_n) begin
            tick_rate    = TICK_RATE_RESET;
            edge_stage   = STAGE_NONE;
            edge_seen    = 1'b0;
            period       = '0;
            rate         = '0;
            o_fail_count = 0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we)
                tick_rate = i_cfg_wdata;
            // result first, so an item accepted at this edge cannot cover for it
            if (m_axis_tvalid && m_axis_tready) begin
                got.rate_q8 = m_axis_tdata[RATE_W-1:0];
                got.stage   = m_axis_tdata[OUT_BITS-1:RATE_W];
                if (expected_readings.size() == 0) begin
                    $error("result item with nothing expected: rate_q8 %0d stage %0d",
                           got.rate_q8, got.stage);
                    o_fail_count++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.rate_q8 !== want.rate_q8) begin
                        $error("rate_q8: expected %0d, actual %0d", want.rate_q8, got.rate_q8);
                        o_fail_count++;
                    end
                    if (got.stage !== want.stage) begin
                        $error("edge_stage_out: expected %0d, actual %0d", want.stage,
                               got.stage);
                        o_fail_count++;
                    end
                end
                if (m_axis_tdata[OUT_DATA_W-1:OUT_BITS] !== '0) begin
                    $error("zero fill: expected 0, actual %0h",
                           m_axis_tdata[OUT_DATA_W-1:OUT_BITS]);
                    o_fail_count++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_event(s_axis_tuser, s_axis_tdata, want);
                expected_readings.push_back(want);
            end
        end
        o_pending = expected_readings.size();
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench top for pulse_period_frequency_meter_unit
// Drives capture and overflow events, writes the tick rate between phases,
// stalls both channels in random bursts and leaves the checking to
// ppfm_checker. Directed corner events first, then random capture windows.
// ----------------------------------------------------------------------------
module tb;
    import ppfm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 275;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [TICK_W-1:0]     i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [COUNT_W-1:0]    s_axis_tdata;   // [15:0] capture_count
    logic                  s_axis_tuser;   // [0] func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [30:0] rate_q8, [32:31] edge_stage_out

    int fail_count;
    int pending;
    int n_cycles;
    int n_sent;
    bit quiet;

    pulse_period_frequency_meter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ppfm_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    initial n_cycles = 0;
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stall bursts, none once quiet
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 6) - 1) @(negedge i_clk);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic put_event(input logic func, input logic [COUNT_W-1:0] count);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = count;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_tick_rate(input logic [TICK_W-1:0] value);
        drain_results();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return COUNT_W'($urandom_range(1, 32));
            1:       return COUNT_W'(16'hFFFF - $urandom_range(0, 15));
            2:       return '0;
            default: return COUNT_W'($urandom());
        endcase
    endfunction

    // mostly capture windows closed by an overflow, some stray events
    task automatic run_random(input int n_items);
        int target;
        target = n_sent + n_items;
        while (n_sent < target) begin
            if ($urandom_range(0, 9) < 8) begin
                repeat ($urandom_range(1, 4)) put_event(FUNC_CAPTURE, pick_count());
                put_event(FUNC_OVERFLOW, COUNT_W'($urandom()));
                if ($urandom_range(0, 3) == 0)
                    put_event(FUNC_OVERFLOW, COUNT_W'($urandom()));
            end else begin
                put_event(1'($urandom()), COUNT_W'($urandom()));
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_CAPTURE;
        quiet         = 1'b0;
        n_sent        = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, at the reset tick rate
        put_event(FUNC_OVERFLOW, '0);           // timeout with no edges
        put_event(FUNC_CAPTURE, '0);            // zero count: no change
        put_event(FUNC_CAPTURE, 16'hFFFF);      // first edge
        put_event(FUNC_OVERFLOW, '0);           // edge seen, stage one: rate kept
        put_event(FUNC_OVERFLOW, 16'hFFFF);     // no edge: rate zeroed, stage reset
        put_event(FUNC_CAPTURE, 16'd1);
        put_event(FUNC_CAPTURE, 16'd1);
        put_event(FUNC_OVERFLOW, '0);           // largest rate
        put_event(FUNC_CAPTURE, 16'hFFFF);
        put_event(FUNC_CAPTURE, '0);
        put_event(FUNC_OVERFLOW, 16'h5555);     // smallest non-zero period rate
        put_event(FUNC_CAPTURE, 16'hAAAA);
        put_event(FUNC_CAPTURE, 16'h5555);
        put_event(FUNC_CAPTURE, 16'h8000);
        put_event(FUNC_OVERFLOW, 16'hAAAA);
        put_event(FUNC_OVERFLOW, '0);
        put_event(FUNC_OVERFLOW, '0);
        put_event(FUNC_CAPTURE, 16'd3);
        put_event(FUNC_OVERFLOW, '0);           // stage one again, rate stays zero

        set_tick_rate(TICK_W'(1));
        put_event(FUNC_CAPTURE, 16'd1);
        put_event(FUNC_CAPTURE, 16'd255);       // 256/255 rounds down
        put_event(FUNC_OVERFLOW, '0);
        run_random(PHASE_ITEMS);

        set_tick_rate(TICK_W'(4194304));
        run_random(PHASE_ITEMS);
        set_tick_rate('1);
        run_random(PHASE_ITEMS);
        set_tick_rate('0);                      // out of range: rate comes out zero
        run_random(PHASE_ITEMS);
        set_tick_rate(TICK_W'($urandom_range(1, 4194304)));
        run_random(PHASE_ITEMS);
        set_tick_rate(TICK_W'($urandom_range(1, 4194304)));
        run_random(PHASE_ITEMS);
        set_tick_rate(TICK_RATE_RESET);
        quiet = 1'b1;
        run_random(PHASE_ITEMS);

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: sim.f
rtl/ppfm_pkg.sv
rtl/ppfm_div.sv
rtl/pulse_period_frequency_meter_unit.sv
tb/sv/ppfm_checker.sv
tb/sv/tb.sv
